@@ src/dtf_pkg.sv @@
// Package: shared constants and types of the decimal text to fixed-point unit.
package dtf_pkg;

	localparam int FRAC_BITS_DEF   = 16;
	localparam int INT_BITS_DEF    = 32;
	localparam int FRAC_DIGITS_DEF = 6;

	localparam int VALUE_W = 48;
	localparam int CHAR_W  = 8;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

	localparam longint unsigned POW_TEN [0:8] = '{
		64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000,
		64'd1000000, 64'd10000000, 64'd100000000
	};

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              last;
	} step_t;

endpackage

@@ src/dtf_parser.sv @@
// Parser: phase register, integer and fraction accumulators, result formation.
module dtf_parser #(
	parameter int FRAC_BITS   = dtf_pkg::FRAC_BITS_DEF,
	parameter int INT_BITS    = dtf_pkg::INT_BITS_DEF,
	parameter int FRAC_DIGITS = dtf_pkg::FRAC_DIGITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step_en,
	input  dtf_pkg::step_t               step,
	output logic [dtf_pkg::VALUE_W-1:0]  value,
	output logic                         saturated
);

	localparam int ISW  = INT_BITS - 1;
	localparam int PW   = ISW + 4;
	localparam int W    = INT_BITS + FRAC_BITS;
	localparam int CNTW = $clog2(FRAC_DIGITS + 1);

	typedef enum logic [5:0] {
		PH_SPACE  = 6'b000001,
		PH_SIGNED = 6'b000010,
		PH_INT    = 6'b000100,
		PH_POINT  = 6'b001000,
		PH_FRAC   = 6'b010000,
		PH_DONE   = 6'b100000
	} phase_t;

	phase_t               phase_q, phase_d, phase_n;
	logic [ISW-1:0]       int_q, int_d, int_n, int_add;
	logic [FRAC_BITS-1:0] frac_q, frac_d, frac_n, frac_add;
	logic [CNTW-1:0]      cnt_q, cnt_d, cnt_n;
	logic                 neg_q, neg_d, neg_n;
	logic                 clamp_q, clamp_d, clamp_n, clamp_add;

	logic [FRAC_BITS-1:0] weight [FRAC_DIGITS];
	logic [FRAC_BITS-1:0] weight_sel;
	logic [FRAC_BITS+3:0] fprod;
	logic [PW-1:0]        prod;
	logic [3:0]           digit;
	logic                 is_dig, is_sep, is_sign, is_ws;
	logic [W-1:0]         mag, sval;
	logic [63:0]          sval_ext;

	// weight of fraction digit k+1: floor(2^FRAC_BITS / 10^(k+1))
	for (genvar k = 0; k < FRAC_DIGITS; k++) begin : g_weight
		localparam longint unsigned WK = (64'd1 << FRAC_BITS) / dtf_pkg::POW_TEN[k+1];
		assign weight[k] = FRAC_BITS'(WK);
	end

	always_comb begin
		is_dig  = (step.char_code >= dtf_pkg::CH_ZERO) && (step.char_code <= dtf_pkg::CH_NINE);
		is_sep  = (step.char_code == dtf_pkg::CH_COMMA) || (step.char_code == dtf_pkg::CH_DOT);
		is_sign = (step.char_code == dtf_pkg::CH_MINUS) || (step.char_code == dtf_pkg::CH_PLUS);
		is_ws   = step.char_code inside {dtf_pkg::CH_SPACE, [dtf_pkg::CH_TAB:dtf_pkg::CH_CR]};
		digit   = is_dig ? step.char_code[3:0] : 4'd0;
	end

	// integer digit: sum*10 + d, clamp at 2^(INT_BITS-1)-1
	always_comb begin
		prod = (PW'(int_q) << 3) + (PW'(int_q) << 1) + PW'(digit);
		if (prod[PW-1:ISW] != '0) begin
			int_add   = '1;
			clamp_add = 1'b1;
		end else begin
			int_add   = prod[ISW-1:0];
			clamp_add = clamp_q;
		end
	end

	always_comb begin
		weight_sel = '0;
		for (int k = 0; k < FRAC_DIGITS; k++) begin
			if (cnt_q == CNTW'(k)) begin
				weight_sel = weight[k];
			end
		end
		fprod    = (FRAC_BITS + 4)'(weight_sel) * (FRAC_BITS + 4)'(digit);
		frac_add = frac_q + fprod[FRAC_BITS-1:0];
	end

	always_comb begin
		phase_d = phase_q;
		int_d   = int_q;
		frac_d  = frac_q;
		cnt_d   = cnt_q;
		neg_d   = neg_q;
		clamp_d = clamp_q;
		case (phase_q)
			PH_SPACE: begin
				if (is_ws) begin
					phase_d = PH_SPACE;
				end else if (is_sign) begin
					neg_d   = (step.char_code == dtf_pkg::CH_MINUS);
					phase_d = PH_SIGNED;
				end else if (is_dig) begin
					int_d   = int_add;
					clamp_d = clamp_add;
					phase_d = PH_INT;
				end else begin
					phase_d = PH_DONE;
				end
			end
			PH_SIGNED: begin
				if (is_dig) begin
					int_d   = int_add;
					clamp_d = clamp_add;
					phase_d = PH_INT;
				end else begin
					neg_d   = 1'b0;
					phase_d = PH_DONE;
				end
			end
			PH_INT: begin
				if (is_dig) begin
					int_d   = int_add;
					clamp_d = clamp_add;
				end else if (is_sep) begin
					phase_d = PH_POINT;
				end else begin
					phase_d = PH_DONE;
				end
			end
			PH_POINT, PH_FRAC: begin
				if (is_dig) begin
					// digits past the table are read but add nothing
					if (cnt_q < CNTW'(FRAC_DIGITS)) begin
						frac_d = frac_add;
						cnt_d  = cnt_q + CNTW'(1);
					end
					phase_d = PH_FRAC;
				end else begin
					phase_d = PH_DONE;
				end
			end
			default: begin
				phase_d = PH_DONE;
			end
		endcase
	end

	// fraction sum stays below 2^FRAC_BITS, so the magnitude is a plain concatenation
	always_comb begin
		mag       = {1'b0, int_d, frac_d};
		sval      = neg_d ? (W'(0) - mag) : mag;
		sval_ext  = 64'(sval);
		value     = sval_ext[dtf_pkg::VALUE_W-1:0];
		saturated = clamp_d;
	end

	// return to the start state after the last character of a string
	always_comb begin
		if (step.last) begin
			phase_n = PH_SPACE;
			int_n   = '0;
			frac_n  = '0;
			cnt_n   = '0;
			neg_n   = 1'b0;
			clamp_n = 1'b0;
		end else begin
			phase_n = phase_d;
			int_n   = int_d;
			frac_n  = frac_d;
			cnt_n   = cnt_d;
			neg_n   = neg_d;
			clamp_n = clamp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			int_q   <= '0;
			frac_q  <= '0;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
			clamp_q <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_n;
			int_q   <= int_n;
			frac_q  <= frac_n;
			cnt_q   <= cnt_n;
			neg_q   <= neg_n;
			clamp_q <= clamp_n;
		end
	end

endmodule

@@ src/dtf_out_reg.sv @@
// Result register: holds one finished number until the downstream side takes it.
module dtf_out_reg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic [dtf_pkg::VALUE_W-1:0]  value_in,
	input  logic                         saturated_in,
	input  logic                         tready,
	output logic                         tvalid,
	output logic [dtf_pkg::VALUE_W-1:0]  tdata,
	output logic                         tuser
);

	logic                        valid_q;
	logic [dtf_pkg::VALUE_W-1:0] value_q;
	logic                        sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_q <= value_in;
			sat_q   <= saturated_in;
		end
	end

	assign tvalid = valid_q;
	assign tdata  = value_q;
	assign tuser  = sat_q;

endmodule

@@ src/decimal_text_to_fixed_point_unit.sv @@
// Top level: decimal text to signed fixed-point converter with stream ports.
// One character is taken per cycle, except while input is held back. Each character goes
// into an input register, is parsed from there by the phase logic and the integer and
// fraction accumulators, and the character marked last loads the result register, so a
// number appears on m_tvalid once its last character has passed the input register.
// Input is held back only while a finished number waits in the result register and the
// character in the input register is itself the last one of the following string.
// Whitespace, sign, integer digits, one comma or dot and up to FRAC_DIGITS fraction digits
// are parsed; the integer part clamps at 2^(INT_BITS-1)-1 and m_tuser reports the clamp.
module decimal_text_to_fixed_point_unit #(
	parameter int FRAC_BITS   = dtf_pkg::FRAC_BITS_DEF,
	parameter int INT_BITS    = dtf_pkg::INT_BITS_DEF,
	parameter int FRAC_DIGITS = dtf_pkg::FRAC_DIGITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,   // [7:0] char_code
	input  logic                         s_tlast,   // last
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [dtf_pkg::VALUE_W-1:0]  m_tdata,   // [47:0] value
	output logic                         m_tuser    // [0] saturated
);

	logic                        valid_s1;
	dtf_pkg::step_t              step_s1;
	logic                        advance;
	logic                        load;
	logic [dtf_pkg::VALUE_W-1:0] res_value;
	logic                        res_sat;

	// hold a last character while the previous number is still waiting
	assign advance  = valid_s1 && !(step_s1.last && m_tvalid && !m_tready);
	assign load     = advance && step_s1.last;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			step_s1.char_code <= s_tdata;
			step_s1.last      <= s_tlast;
		end
	end

	dtf_parser #(
		.FRAC_BITS   (FRAC_BITS),
		.INT_BITS    (INT_BITS),
		.FRAC_DIGITS (FRAC_DIGITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.step      (step_s1),
		.value     (res_value),
		.saturated (res_sat)
	);

	dtf_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.value_in     (res_value),
		.saturated_in (res_sat),
		.tready       (m_tready),
		.tvalid       (m_tvalid),
		.tdata        (m_tdata),
		.tuser        (m_tuser)
	);

`ifndef ASSERT_OFF
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!m_tvalid || m_tready))
		else $error("result register loaded while a number is pending");

	a_rise_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_s1 && step_s1.last))
		else $error("result shown without a last character");

	a_sat_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata != '0))
		else $error("clamped result reads as zero");
`endif

endmodule

@@ bench/testbench.sv @@
// Testbench: streams decimal text into the converter and checks each number it returns.
`timescale 1ns / 1ps

module testbench;
	import dtf_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam longint unsigned INT_LIMIT = (64'd1 << (INT_BITS_DEF - 1)) - 64'd1;

	typedef enum logic [2:0] {
		SCAN_SPACE,
		SCAN_SIGN,
		SCAN_INT,
		SCAN_POINT,
		SCAN_FRAC,
		SCAN_DONE
	} scan_phase_t;

	typedef struct {
		logic [VALUE_W-1:0] value;
		logic               saturated;
	} number_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata = 8'h00;
	logic               s_tlast = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [VALUE_W-1:0] m_tdata;
	logic               m_tuser;

	step_t   pending_chars [$];
	number_t expected_numbers [$];
	step_t   next_char;
	number_t oldest_number;

	int sender_idle_pct = 22;
	int receiver_idle_pct = 74;
	int error_count = 0;
	int chars_queued = 0;
	int cycle_count = 0;

	// predictor state
	scan_phase_t       scan_phase = SCAN_SPACE;
	longint unsigned   int_sum = 0;
	longint unsigned   frac_sum = 0;
	int                frac_count = 0;
	bit                negative = 1'b0;
	bit                clamped = 1'b0;

	decimal_text_to_fixed_point_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic add_int_digit(input logic [3:0] d);
		longint unsigned next_sum;
		next_sum = int_sum * 10 + d;
		if (next_sum > INT_LIMIT) begin
			next_sum = INT_LIMIT;
			clamped = 1'b1;
		end
		int_sum = next_sum;
	endtask

	// Advance the parser by one character; on the last one, queue the expected number.
	task automatic predict_char(input logic [7:0] c, input logic fin);
		bit              is_dig;
		bit              is_sep;
		bit              is_ws;
		logic [3:0]      d;
		longint unsigned mag;
		longint unsigned signed_mag;
		number_t         num;
		is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
		is_sep = (c == CH_COMMA) || (c == CH_DOT);
		is_ws = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
		d = c[3:0];
		case (scan_phase)
			SCAN_SPACE: begin
				if (is_ws) begin
				end else if (c == CH_MINUS || c == CH_PLUS) begin
					negative = (c == CH_MINUS);
					scan_phase = SCAN_SIGN;
				end else if (is_dig) begin
					add_int_digit(d);
					scan_phase = SCAN_INT;
				end else begin
					scan_phase = SCAN_DONE;
				end
			end
			SCAN_SIGN: begin
				if (is_dig) begin
					add_int_digit(d);
					scan_phase = SCAN_INT;
				end else begin
					negative = 1'b0;
					scan_phase = SCAN_DONE;
				end
			end
			SCAN_INT: begin
				if (is_dig)
					add_int_digit(d);
				else if (is_sep)
					scan_phase = SCAN_POINT;
				else
					scan_phase = SCAN_DONE;
			end
			SCAN_POINT, SCAN_FRAC: begin
				if (is_dig) begin
					if (frac_count < FRAC_DIGITS_DEF) begin
						frac_count++;
						frac_sum += d * ((64'd1 << FRAC_BITS_DEF) / POW_TEN[frac_count]);
					end
					scan_phase = SCAN_FRAC;
				end else begin
					scan_phase = SCAN_DONE;
				end
			end
			default: scan_phase = SCAN_DONE;
		endcase
		if (fin) begin
			mag = (int_sum << FRAC_BITS_DEF) + frac_sum;
			signed_mag = negative ? (64'd0 - mag) : mag;
			num.value = signed_mag[VALUE_W-1:0];
			num.saturated = clamped;
			expected_numbers.push_back(num);
			scan_phase = SCAN_SPACE;
			int_sum = 0;
			frac_sum = 0;
			frac_count = 0;
			negative = 1'b0;
			clamped = 1'b0;
		end
	endtask

	task automatic push_char(input logic [7:0] c, input logic fin);
		step_t it;
		it.char_code = c;
		it.last = fin;
		pending_chars.push_back(it);
		chars_queued++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i], i == s.len() - 1);
	endtask

	function automatic logic [7:0] random_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	// Mostly well-formed numbers with random content, the rest broken or plain noise.
	task automatic push_random_number();
		logic [7:0] text [$];
		int         kind;
		int         n;
		kind = $urandom_range(0, 99);
		if (kind < 80) begin
			n = $urandom_range(0, 2);
			repeat (n)
				text.push_back(($urandom_range(0, 5) == 0) ? CH_SPACE : 8'($urandom_range(9, 13)));
			if ($urandom_range(0, 99) < 40)
				text.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
			n = ($urandom_range(0, 99) < 20) ? $urandom_range(9, 12) : $urandom_range(1, 4);
			repeat (n)
				text.push_back(random_digit());
			if ($urandom_range(0, 99) < 60) begin
				text.push_back($urandom_range(0, 1) ? CH_DOT : CH_COMMA);
				n = $urandom_range(0, 8);
				if ($urandom_range(0, 9) == 0)
					repeat (n) text.push_back(CH_NINE);
				else
					repeat (n) text.push_back(random_digit());
			end
			if ($urandom_range(0, 99) < 30) begin
				n = $urandom_range(1, 3);
				repeat (n) text.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
			end
		end else if (kind < 90) begin
			case ($urandom_range(0, 2))
				0: text.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
				1: text.push_back($urandom_range(0, 1) ? CH_DOT : CH_COMMA);
				default: begin
					text.push_back(random_digit());
					text.push_back($urandom_range(0, 1) ? CH_DOT : CH_COMMA);
				end
			endcase
			n = $urandom_range(0, 3);
			repeat (n) text.push_back(8'($urandom));
		end else begin
			n = $urandom_range(1, 5);
			repeat (n) text.push_back(8'($urandom));
		end
		foreach (text[i])
			push_char(text[i], i == text.size() - 1);
	endtask

	task automatic run_random(input int count);
		int target;
		target = chars_queued + count;
		while (chars_queued < target)
			push_random_number();
	endtask

	// Hold until every queued character is taken and every number has come back.
	task automatic drain();
		while (pending_chars.size() != 0 || s_tvalid)
			@(negedge clk);
		while (expected_numbers.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_char(s_tdata, s_tlast);
			if (!s_tvalid || s_tready) begin
				if (pending_chars.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					next_char = pending_chars.pop_front();
					s_tdata <= next_char.char_code;
					s_tlast <= next_char.last;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_numbers.size() == 0) begin
					$error("unexpected number: value %h saturated %b", m_tdata, m_tuser);
					error_count++;
				end else begin
					oldest_number = expected_numbers.pop_front();
					if (m_tdata !== oldest_number.value) begin
						$error("value mismatch: expected %h, got %h", oldest_number.value, m_tdata);
						error_count++;
					end
					if (m_tuser !== oldest_number.saturated) begin
						$error("saturated mismatch: expected %b, got %b",
							oldest_number.saturated, m_tuser);
						error_count++;
					end
				end
			end
			m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[decimal_text_to_fixed_point_unit] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		push_text("-0");
		push_text(".5");
		push_text("-x");
		push_char(8'hFF, 1'b1);
		push_text("7,x");
		push_char(8'h0B, 1'b0);
		push_char(CH_PLUS, 1'b0);
		push_char(8'h33, 1'b0);
		push_char(8'h00, 1'b0);
		push_char(8'h35, 1'b1);
		push_text("-2147483648");
		drain();

		run_random(580);
		drain();

		sender_idle_pct = 74;
		receiver_idle_pct = 22;
		run_random(560);
		drain();

		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		run_random(560);
		drain();

		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("[decimal_text_to_fixed_point_unit] OK");
		else
			$display("[decimal_text_to_fixed_point_unit] ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
src/dtf_pkg.sv
src/dtf_parser.sv
src/dtf_out_reg.sv
src/decimal_text_to_fixed_point_unit.sv
bench/testbench.sv
